[hdl/mpf_pkg.sv]
// Package for the mosaic pixelation filter: field widths, register codes,
// reset values and the stage record passed from control to output.
// No dependencies.
package mpf_pkg;

    localparam int MAX_WIDTH_DEF      = 2048;
    localparam int MAX_HALF_BLOCK_DEF = 7;
    localparam int MAX_HEIGHT         = 2048;
    localparam int ROW_W              = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W           = ROW_W + 1;

    localparam int PIX_W     = 24;
    localparam int BS_W      = 4;
    localparam int DIM_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = 4'd5;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT
    } cfg_index_t;

    // One result on its way from the memory read to the output register.
    typedef struct packed {
        logic             direct;      // take direct_data, not a memory word
        logic             sel_center;  // take the center word, not the delayed pixel
        logic [PIX_W-1:0] direct_data;
        logic             last;
    } stage_t;

endpackage

[hdl/mpf_ram.sv]
// Simple dual-port synchronous RAM: one write and one read port, registered
// read data, held while the read enable is low.
// No dependencies.
module mpf_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                      wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mpf_ctrl.sv]
// Control of the mosaic filter: configuration registers, input and output
// raster positions, delay line pointers and fill count, memory commands.
// Depends on mpf_pkg.
module mpf_ctrl
    import mpf_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_HALF_BLOCK = MAX_HALF_BLOCK_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 in_cmd,
    input  logic [PIX_W-1:0]     in_pixel,
    output logic                 dly_we,
    output logic [$clog2(MAX_HALF_BLOCK*MAX_WIDTH+MAX_HALF_BLOCK)-1:0] dly_waddr,
    output logic [PIX_W-1:0]     dly_wdata,
    output logic                 dly_re,
    output logic [$clog2(MAX_HALF_BLOCK*MAX_WIDTH+MAX_HALF_BLOCK)-1:0] dly_raddr,
    output logic                 ctr_we,
    output logic [$clog2(MAX_WIDTH/3)-1:0] ctr_waddr,
    output logic [PIX_W-1:0]     ctr_wdata,
    output logic                 ctr_re,
    output logic [$clog2(MAX_WIDTH/3)-1:0] ctr_raddr,
    output logic                 stage_load,
    output stage_t               stage_info
);

    localparam int DELAY_DEPTH  = MAX_HALF_BLOCK * MAX_WIDTH + MAX_HALF_BLOCK;
    localparam int CENTER_DEPTH = MAX_WIDTH / 3;
    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int CIW  = $clog2(CENTER_DEPTH);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int DLW  = $clog2(DELAY_DEPTH + 1);
    localparam int NMAX = 2 * MAX_HALF_BLOCK + 1;

    typedef struct packed {
        logic [CW-1:0]    col;
        logic [ROW_W-1:0] row;
        logic [BS_W-1:0]  sub_col;
        logic [BS_W-1:0]  sub_row;
        logic [CW-1:0]    blk_col;
        logic [CW-1:0]    col_base;
        logic [ROW_W-1:0] row_base;
    } pos_t;

    logic [BS_W-1:0]     block_size_reg, block_size_next;
    logic [DIM_W-1:0]    frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]    frame_height_reg, frame_height_next;
    pos_t                in_pos_reg, in_pos_next;
    pos_t                out_pos_reg, out_pos_next;
    logic [DLW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]       rd_reg, rd_next;
    logic [AW-1:0]       wr_reg, wr_next;
    logic                drain_reg, drain_next;

    logic [BS_W-1:0]     eff_n;
    logic [BS_W-2:0]     half;
    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [DLW-1:0]      delay_len;
    logic                accept;
    pos_t                out_eff;
    logic [DLW-1:0]      fill_eff;
    logic [AW-1:0]       rd_eff;
    logic                out_full;
    logic                out_last;
    logic                in_last;
    logic                center_hit;
    logic [CIW-1:0]      center_idx;
    logic [DLW-1:0]      ptr_gap;

    // Effective configuration: odd block edge with a cap, clamped frame size.
    always_comb
    begin
        eff_n = block_size_reg | BS_W'(1);
        if (int'(eff_n) > NMAX)
        begin
            eff_n = BS_W'(NMAX);
        end
        half = eff_n[BS_W-1:1];
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (int'(frame_height_reg) > MAX_HEIGHT)
        begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HEIGHT_W'(frame_height_reg);
        end
        delay_len = DLW'(half) * DLW'(eff_w) + DLW'(half);
    end

    function automatic pos_t pos_advance(pos_t p, logic [BS_W-1:0] n,
                                         logic [WW-1:0] w, logic [HEIGHT_W-1:0] h);
        pos_t q;
        q = p;
        if (WW'(p.col) + WW'(1) >= w)
        begin
            q.col      = '0;
            q.sub_col  = '0;
            q.blk_col  = '0;
            q.col_base = '0;
            if (HEIGHT_W'(p.row) + HEIGHT_W'(1) >= h)
            begin
                q.row      = '0;
                q.sub_row  = '0;
                q.row_base = '0;
            end
            else
            begin
                q.row = p.row + ROW_W'(1);
                if (p.sub_row == n - BS_W'(1))
                begin
                    q.sub_row  = '0;
                    q.row_base = p.row_base + ROW_W'(n);
                end
                else
                begin
                    q.sub_row = p.sub_row + BS_W'(1);
                end
            end
        end
        else
        begin
            q.col = p.col + CW'(1);
            if (p.sub_col == n - BS_W'(1))
            begin
                q.sub_col  = '0;
                q.blk_col  = p.blk_col + CW'(1);
                q.col_base = p.col_base + CW'(n);
            end
            else
            begin
                q.sub_col = p.sub_col + BS_W'(1);
            end
        end
        return q;
    endfunction

    // A position is in a full block when n is not 1 and its block ends inside the frame.
    function automatic logic pos_full(pos_t p, logic [BS_W-1:0] n,
                                      logic [WW-1:0] w, logic [HEIGHT_W-1:0] h);
        logic col_ok;
        logic row_ok;
        col_ok = ((WW+1)'(p.col_base) + (WW+1)'(n)) <= (WW+1)'(w);
        row_ok = (HEIGHT_W'(p.row_base) + HEIGHT_W'(n)) <= h;
        return (n != BS_W'(1)) && col_ok && row_ok;
    endfunction

    function automatic logic pos_last(pos_t p, logic [WW-1:0] w,
                                      logic [HEIGHT_W-1:0] h);
        return (HEIGHT_W'(p.row) + HEIGHT_W'(1) == h) && (WW'(p.col) + WW'(1) == w);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(DELAY_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign accept = in_valid && in_ready;

    always_comb
    begin
        block_size_next   = block_size_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_pos_next       = in_pos_reg;
        out_pos_next      = out_pos_reg;
        fill_next         = fill_reg;
        rd_next           = rd_reg;
        wr_next           = wr_reg;
        drain_next        = drain_reg;

        dly_we     = 1'b0;
        dly_waddr  = wr_reg;
        dly_wdata  = in_pixel;
        dly_re     = 1'b0;
        dly_raddr  = rd_reg;
        ctr_we     = 1'b0;
        ctr_wdata  = in_pixel;
        ctr_re     = 1'b0;
        stage_load = 1'b0;
        stage_info = '0;

        // A pixel after a partial drain starts over with an empty delay line.
        if (!in_cmd && drain_reg)
        begin
            out_eff  = '0;
            fill_eff = '0;
            rd_eff   = wr_reg;
        end
        else
        begin
            out_eff  = out_pos_reg;
            fill_eff = fill_reg;
            rd_eff   = rd_reg;
        end

        out_full   = pos_full(out_eff, eff_n, eff_w, eff_h);
        out_last   = pos_last(out_eff, eff_w, eff_h);
        in_last    = pos_last(in_pos_reg, eff_w, eff_h);
        center_idx = in_pos_reg.blk_col[CIW-1:0];
        center_hit = pos_full(in_pos_reg, eff_n, eff_w, eff_h)
                     && (in_pos_reg.sub_row == {1'b0, half})
                     && (in_pos_reg.sub_col == {1'b0, half});
        ctr_waddr  = center_idx;
        ctr_raddr  = out_eff.blk_col[CIW-1:0];

        if (accept)
        begin
            if (in_cmd)
            begin
                if (fill_reg != '0 && in_pos_reg.col == '0 && in_pos_reg.row == '0)
                begin
                    stage_load            = 1'b1;
                    dly_re                = 1'b1;
                    ctr_re                = out_full;
                    stage_info.sel_center = out_full;
                    stage_info.last       = out_last;
                    rd_next               = ptr_inc(rd_reg);
                    out_pos_next          = pos_advance(out_pos_reg, eff_n, eff_w, eff_h);
                    fill_next             = fill_reg - DLW'(1);
                    drain_next            = (fill_reg != DLW'(1));
                end
            end
            else
            begin
                drain_next = 1'b0;
                ctr_we     = center_hit;
                if (delay_len == '0)
                begin
                    stage_load             = 1'b1;
                    stage_info.direct      = 1'b1;
                    stage_info.direct_data = in_pixel;
                    stage_info.last        = in_last;
                    rd_next                = rd_eff;
                    fill_next              = fill_eff;
                    out_pos_next           = out_eff;
                    in_pos_next = pos_advance(in_pos_reg, eff_n, eff_w, eff_h);
                end
                else
                begin
                    if (fill_eff >= delay_len)
                    begin
                        stage_load            = 1'b1;
                        dly_re                = 1'b1;
                        dly_raddr             = rd_eff;
                        ctr_re                = out_full;
                        stage_info.sel_center = out_full;
                        // The center written by this very pixel is not yet in the RAM.
                        stage_info.direct     = out_full && center_hit
                                                && (center_idx == ctr_raddr);
                        stage_info.direct_data = in_pixel;
                        stage_info.last       = out_last;
                        rd_next               = ptr_inc(rd_eff);
                        out_pos_next          = pos_advance(out_eff, eff_n, eff_w, eff_h);
                        fill_next             = fill_eff;
                    end
                    else
                    begin
                        rd_next      = rd_eff;
                        out_pos_next = out_eff;
                        fill_next    = fill_eff + DLW'(1);
                    end
                    dly_we      = 1'b1;
                    wr_next     = ptr_inc(wr_reg);
                    in_pos_next = pos_advance(in_pos_reg, eff_n, eff_w, eff_h);
                end
            end
        end

        // Any register write restarts the stream.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:
                begin
                    block_size_next = cfg_wdata[BS_W-1:0];
                end
                CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_wdata;
                end
                CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_wdata;
                end
                default:
                begin
                end
            endcase
            if (cfg_index == CFG_BLOCK_SIZE || cfg_index == CFG_FRAME_WIDTH
                || cfg_index == CFG_FRAME_HEIGHT)
            begin
                in_pos_next  = '0;
                out_pos_next = '0;
                fill_next    = '0;
                rd_next      = '0;
                wr_next      = '0;
                drain_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= BLOCK_SIZE_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            in_pos_reg       <= '0;
            out_pos_reg      <= '0;
            fill_reg         <= '0;
            rd_reg           <= '0;
            wr_reg           <= '0;
            drain_reg        <= 1'b0;
        end
        else
        begin
            block_size_reg   <= block_size_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_pos_reg       <= in_pos_next;
            out_pos_reg      <= out_pos_next;
            fill_reg         <= fill_next;
            rd_reg           <= rd_next;
            wr_reg           <= wr_next;
            drain_reg        <= drain_next;
        end
    end

    // Distance from the read to the write pointer around the ring.
    assign ptr_gap = (wr_reg >= rd_reg) ? (DLW'(wr_reg) - DLW'(rd_reg))
                                        : (DLW'(wr_reg) + DLW'(DELAY_DEPTH) - DLW'(rd_reg));

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= delay_len)
        else $error("delay line holds more pixels than the configured delay");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> fill_reg != '0)
        else $error("drain in progress with an empty delay line");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_gap == fill_reg) || (ptr_gap == '0 && fill_reg == DLW'(DELAY_DEPTH)))
        else $error("ring pointers disagree with the fill count");

endmodule

[hdl/mpf_out.sv]
// Output side of the mosaic filter: the memory read stage and the output
// register, with the pixel select and the ready chain toward the input.
// Depends on mpf_pkg.
module mpf_out
    import mpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  stage_t           info,
    input  logic [PIX_W-1:0] delay_q,
    input  logic [PIX_W-1:0] center_q,
    output logic             s1_free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel,
    output logic             out_last
);

    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_info_reg;
    logic             s2_valid_reg, s2_valid_next;
    logic [PIX_W-1:0] s2_data_reg;
    logic             s2_last_reg;
    logic             s2_free;
    logic             s1_move;
    logic [PIX_W-1:0] s1_pixel;

    assign s2_free = !s2_valid_reg || out_ready;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s1_move = s1_valid_reg && s2_free;

    always_comb
    begin
        if (s1_info_reg.direct)
        begin
            s1_pixel = s1_info_reg.direct_data;
        end
        else if (s1_info_reg.sel_center)
        begin
            s1_pixel = center_q;
        end
        else
        begin
            s1_pixel = delay_q;
        end

        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_info_reg <= info;
        end
        if (s1_move)
        begin
            s2_data_reg <= s1_pixel;
            s2_last_reg <= s1_info_reg.last;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pixel = s2_data_reg;
    assign out_last  = s2_last_reg;

    // A new read may only start when the read stage is emptied at the same edge.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> s1_free)
        else $error("memory read issued while the read stage is held");

endmodule

[hdl/mosaic_pixelate_filter.sv]
// Mosaic pixelation filter on a raster pixel stream, one pixel per clock while s_axis_tready is high.
// Latency: a pixel leaves with the transaction that comes h*W+h pixel transactions
// after it (or a flush at frame end), h = half block, W = frame width; its result
// goes through the read stage and the output register before it is valid on m_axis.
// Throughput: one transaction per clock; s_axis_tready drops only while both output
// registers are full. Reset clears positions and counts, loads 5/640/480, not memories.
module mosaic_pixelate_filter
    import mpf_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_HALF_BLOCK = MAX_HALF_BLOCK_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [23:0] pixel
    input  logic [0:0]           s_axis_tuser,   // [0] cmd (flush)
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [23:0] pixel_out
    output logic                 m_axis_tlast
);

    localparam int DELAY_DEPTH  = MAX_HALF_BLOCK * MAX_WIDTH + MAX_HALF_BLOCK;
    localparam int CENTER_DEPTH = MAX_WIDTH / 3;
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int CIW = $clog2(CENTER_DEPTH);

    logic             dly_we;
    logic [AW-1:0]    dly_waddr;
    logic [PIX_W-1:0] dly_wdata;
    logic             dly_re;
    logic [AW-1:0]    dly_raddr;
    logic [PIX_W-1:0] dly_q;
    logic             ctr_we;
    logic [CIW-1:0]   ctr_waddr;
    logic [PIX_W-1:0] ctr_wdata;
    logic             ctr_re;
    logic [CIW-1:0]   ctr_raddr;
    logic [PIX_W-1:0] ctr_q;
    logic             stage_load;
    stage_t           stage_info;
    logic             s1_free;

    assign s_axis_tready = s1_free;

    mpf_ctrl #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HALF_BLOCK (MAX_HALF_BLOCK)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s1_free),
        .in_cmd     (s_axis_tuser[0]),
        .in_pixel   (s_axis_tdata),
        .dly_we     (dly_we),
        .dly_waddr  (dly_waddr),
        .dly_wdata  (dly_wdata),
        .dly_re     (dly_re),
        .dly_raddr  (dly_raddr),
        .ctr_we     (ctr_we),
        .ctr_waddr  (ctr_waddr),
        .ctr_wdata  (ctr_wdata),
        .ctr_re     (ctr_re),
        .ctr_raddr  (ctr_raddr),
        .stage_load (stage_load),
        .stage_info (stage_info)
    );

    mpf_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .re    (dly_re),
        .raddr (dly_raddr),
        .rdata (dly_q)
    );

    mpf_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (CENTER_DEPTH)
    ) u_center_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_q)
    );

    mpf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_load),
        .info      (stage_info),
        .delay_q   (dly_q),
        .center_q  (ctr_q),
        .s1_free   (s1_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
